// ===== hw/rtl/spq_pkg.sv =====
package spq_pkg;

	localparam int DEPTH  = 16;
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int OCC_W  = 5;
	localparam int ID_W   = 16;
	localparam int KEY_W  = 8;

	typedef enum logic {
		MODE_INSERT  = 1'b0,
		MODE_EXTRACT = 1'b1
	} mode_t;

	typedef enum logic [1:0] {
		STAT_INSERTED  = 2'd0,
		STAT_EXTRACTED = 2'd1,
		STAT_EMPTY     = 2'd2,
		STAT_FULL      = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SHIFT,
		ST_PLACE,
		ST_EXTRACT
	} state_t;

	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [ID_W-1:0]  id;
	} entry_t;

	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] waddr;
		entry_t            wdata;
		logic              re;
		logic [ADDR_W-1:0] raddr;
	} mem_req_t;

endpackage

// ===== hw/rtl/sorted_priority_queue_core.sv =====
// sorted priority queue in one memory, descending key order, one transaction at a time
// extract: tail read when accepted, finished in ST_EXTRACT; empty queue, full queue or
// insert into an empty queue: finished when accepted; other inserts: ST_SHIFT moves each
// held entry with a smaller key up one place, then writes the new entry, or ST_PLACE puts it
// at the head; done is registered, lasts one cycle and cannot be stalled; busy is low then, so
// the next start is taken at the edge that ends it; arst_n clears state and count, not memory
module sorted_priority_queue_core
	import spq_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  logic             mode,
	input  logic [ID_W-1:0]  item_id,
	input  logic [KEY_W-1:0] days,
	output logic             done,
	output logic [1:0]       status,
	output logic [ID_W-1:0]  out_id,
	output logic [KEY_W-1:0] out_days,
	output logic [OCC_W-1:0] occupancy
);

	mem_req_t req;
	entry_t   rdata;

	spq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.mode      (mode),
		.item_id   (item_id),
		.days      (days),
		.busy      (busy),
		.done      (done),
		.status    (status),
		.out_id    (out_id),
		.out_days  (out_days),
		.occupancy (occupancy),
		.req       (req),
		.rdata     (rdata)
	);

	spq_ram u_ram (
		.clk   (clk),
		.req   (req),
		.rdata (rdata)
	);

endmodule

// ===== hw/rtl/spq_ram.sv =====
module spq_ram
	import spq_pkg::*;
(
	input  logic     clk,
	input  mem_req_t req,
	output entry_t   rdata
);

	entry_t mem [DEPTH];
	entry_t rdata_q;

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
		if (req.re) begin
			rdata_q <= mem[req.raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== hw/rtl/spq_ctrl.sv =====
module spq_ctrl
	import spq_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic             mode,
	input  logic [ID_W-1:0]  item_id,
	input  logic [KEY_W-1:0] days,
	output logic             busy,
	output logic             done,
	output logic [1:0]       status,
	output logic [ID_W-1:0]  out_id,
	output logic [KEY_W-1:0] out_days,
	output logic [OCC_W-1:0] occupancy,
	output mem_req_t         req,
	input  entry_t           rdata
);

	state_t            state_q, state_d;
	logic [ADDR_W-1:0] idx_q, idx_d;
	logic [CNT_W-1:0]  cnt_q, cnt_d;
	entry_t            new_q;
	logic              load_new;
	logic              accept;
	logic              fin;
	status_t           res_status;
	entry_t            res_ent;
	logic              done_q;
	status_t           status_q;
	entry_t            out_q;
	logic [OCC_W-1:0]  occ_q;
	logic              full, empty;

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;
	assign full   = (cnt_q >= CNT_W'(DEPTH));
	assign empty  = (cnt_q == '0);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && !empty) begin
					if (mode == MODE_EXTRACT) begin
						state_d = ST_EXTRACT;
					end else if (!full) begin
						state_d = ST_SHIFT;
					end
				end
			end
			ST_SHIFT: begin
				if (rdata.key >= new_q.key) begin
					state_d = ST_IDLE;
				end else if (idx_q == '0) begin
					state_d = ST_PLACE;
				end
			end
			ST_PLACE:   state_d = ST_IDLE;
			ST_EXTRACT: state_d = ST_IDLE;
			default:    state_d = ST_IDLE;
		endcase
	end

	// memory requests and results
	always_comb begin
		req        = '0;
		fin        = 1'b0;
		res_status = STAT_INSERTED;
		res_ent    = '0;
		cnt_d      = cnt_q;
		idx_d      = idx_q;
		load_new   = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (mode == MODE_INSERT) begin
						load_new = 1'b1;
						if (full) begin
							fin        = 1'b1;
							res_status = STAT_FULL;
						end else if (empty) begin
							req.we    = 1'b1;
							req.waddr = '0;
							req.wdata = '{key: days, id: item_id};
							cnt_d     = cnt_q + 1'b1;
							fin       = 1'b1;
						end else begin
							// walk from the tail towards the head
							req.re    = 1'b1;
							req.raddr = ADDR_W'(cnt_q - 1'b1);
							idx_d     = ADDR_W'(cnt_q - 1'b1);
						end
					end else begin
						if (empty) begin
							fin        = 1'b1;
							res_status = STAT_EMPTY;
						end else begin
							req.re    = 1'b1;
							req.raddr = ADDR_W'(cnt_q - 1'b1);
						end
					end
				end
			end
			ST_SHIFT: begin
				req.we    = 1'b1;
				req.waddr = idx_q + 1'b1;
				if (rdata.key >= new_q.key) begin
					req.wdata = new_q;
					cnt_d     = cnt_q + 1'b1;
					fin       = 1'b1;
				end else begin
					// smaller key moves up one place, never the address read next
					req.wdata = rdata;
					if (idx_q != '0) begin
						req.re    = 1'b1;
						req.raddr = idx_q - 1'b1;
						idx_d     = idx_q - 1'b1;
					end
				end
			end
			ST_PLACE: begin
				req.we    = 1'b1;
				req.waddr = '0;
				req.wdata = new_q;
				cnt_d     = cnt_q + 1'b1;
				fin       = 1'b1;
			end
			ST_EXTRACT: begin
				cnt_d      = cnt_q - 1'b1;
				fin        = 1'b1;
				res_status = STAT_EXTRACTED;
				res_ent    = rdata;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			done_q  <= fin;
		end
	end

	always_ff @(posedge clk) begin
		idx_q <= idx_d;
		if (load_new) begin
			new_q <= '{key: days, id: item_id};
		end
		if (fin) begin
			status_q <= res_status;
			out_q    <= res_ent;
			occ_q    <= OCC_W'(cnt_d);
		end
	end

	assign done      = done_q;
	assign status    = status_q;
	assign out_id    = out_q.id;
	assign out_days  = out_q.key;
	assign occupancy = occ_q;

endmodule

// ===== hw/rtl/spq_checker.sv =====
module spq_checker
	import spq_pkg::*;
(
	input logic             clk,
	input logic             arst_n,
	input logic             busy,
	input logic             done,
	input logic [1:0]       status,
	input logic [ID_W-1:0]  out_id,
	input logic [KEY_W-1:0] out_days,
	input logic [OCC_W-1:0] occupancy
);

	// a multi-cycle transaction ends with its result
	a_fell_busy_done: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("busy fell without a result");

	a_no_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !done)
		else $error("result while still busy");

	a_full_occ: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == STAT_FULL) |-> (occupancy == OCC_W'(DEPTH) && out_id == '0))
		else $error("full result with wrong fields");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == STAT_EMPTY) |->
			(occupancy == '0 && out_id == '0 && out_days == '0))
		else $error("empty result with non-zero fields");

	a_ins_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == STAT_INSERTED) |-> (out_id == '0 && out_days == '0))
		else $error("insert result carries an entry");

endmodule

bind sorted_priority_queue_core spq_checker u_spq_checker (.*);

// ===== test/sorted_priority_queue_core_tb.sv =====
module sorted_priority_queue_core_tb;
	import spq_pkg::*;

	localparam int STALL_LIMIT = 1000;
	localparam int DRAIN_CYCLES = DEPTH + 8;

	typedef struct {
		status_t          status;
		logic [ID_W-1:0]  id;
		logic [KEY_W-1:0] days;
		logic [OCC_W-1:0] occ;
	} queue_result_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             start = 1'b0;
	logic             busy;
	logic             mode = MODE_INSERT;
	logic [ID_W-1:0]  item_id = '0;
	logic [KEY_W-1:0] days = '0;
	logic             done;
	logic [1:0]       status;
	logic [ID_W-1:0]  out_id;
	logic [KEY_W-1:0] out_days;
	logic [OCC_W-1:0] occupancy;

	// shadow copy of the queue, descending key order
	logic [KEY_W-1:0] shadow_keys [DEPTH];
	logic [ID_W-1:0]  shadow_ids [DEPTH];
	int               shadow_count = 0;

	queue_result_t pending_results[$];
	int            error_count = 0;
	int            stall_cycles = 0;
	int unsigned   idle_pct = 0;

	sorted_priority_queue_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.mode      (mode),
		.item_id   (item_id),
		.days      (days),
		.done      (done),
		.status    (status),
		.out_id    (out_id),
		.out_days  (out_days),
		.occupancy (occupancy)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic queue_result_t predict_queue_op(mode_t op, logic [ID_W-1:0] id,
			logic [KEY_W-1:0] key);
		queue_result_t r;
		int pos;
		int i;
		r.status = STAT_INSERTED;
		r.id = '0;
		r.days = '0;
		if (op == MODE_INSERT) begin
			if (shadow_count >= DEPTH) begin
				r.status = STAT_FULL;
			end else begin
				// new entry goes behind every key greater or equal
				pos = 0;
				while (pos < shadow_count && shadow_keys[pos] >= key)
					pos++;
				for (i = shadow_count; i > pos; i--) begin
					shadow_keys[i] = shadow_keys[i-1];
					shadow_ids[i] = shadow_ids[i-1];
				end
				shadow_keys[pos] = key;
				shadow_ids[pos] = id;
				shadow_count++;
			end
		end else if (shadow_count == 0) begin
			r.status = STAT_EMPTY;
		end else begin
			shadow_count--;
			r.id = shadow_ids[shadow_count];
			r.days = shadow_keys[shadow_count];
			r.status = STAT_EXTRACTED;
		end
		r.occ = OCC_W'(shadow_count);
		return r;
	endfunction

	function automatic logic [KEY_W-1:0] pick_days();
		case ($urandom_range(3))
			0, 1: return KEY_W'($urandom_range(255));
			// narrow range so that ties are common
			2: return KEY_W'($urandom_range(3));
			default: return $urandom_range(1) ? 8'hFF : 8'h00;
		endcase
	endfunction

	// one transaction; start stays high afterwards so back-to-back items need no gap
	task automatic send_op(mode_t op, logic [ID_W-1:0] id, logic [KEY_W-1:0] key);
		int gap;
		if ($urandom_range(99) < idle_pct) begin
			gap = $urandom_range(1, 3);
			start <= 1'b0;
			repeat (gap) begin
				mode <= 1'($urandom_range(1));
				item_id <= ID_W'($urandom);
				days <= KEY_W'($urandom);
				@(posedge clk);
			end
		end
		start <= 1'b1;
		mode <= op;
		item_id <= id;
		days <= key;
		@(posedge clk);
		while (busy !== 1'b0)
			@(posedge clk);
		pending_results.push_back(predict_queue_op(op, id, key));
	endtask

	task automatic test_directed_cases();
		idle_pct = 0;
		send_op(MODE_EXTRACT, 16'hFFFF, 8'hFF);
		send_op(MODE_INSERT, 16'h0000, 8'h00);
		send_op(MODE_INSERT, 16'hFFFF, 8'hFF);
		send_op(MODE_INSERT, 16'h1234, 8'h80);
		send_op(MODE_INSERT, 16'h5678, 8'h80);
		send_op(MODE_INSERT, 16'hA5A5, 8'h00);
		send_op(MODE_INSERT, 16'h5A5A, 8'h7F);
		repeat (7)
			send_op(MODE_EXTRACT, 16'h0000, 8'h00);
		send_op(MODE_INSERT, 16'h8001, 8'h01);
		send_op(MODE_EXTRACT, 16'hFFFF, 8'hFF);
	endtask

	// fill past full, then empty past empty
	task automatic test_overflow();
		idle_pct = 25;
		repeat (DEPTH + 2)
			send_op(MODE_INSERT, ID_W'($urandom), pick_days());
		repeat (DEPTH + 2)
			send_op(MODE_EXTRACT, ID_W'($urandom), KEY_W'($urandom));
	endtask

	// runs biased towards insert or extract sweep the fill level across its range
	task automatic test_random_mix(int unsigned n_ops, int unsigned pct);
		int unsigned insert_pct;
		int unsigned run_left;
		mode_t op;
		idle_pct = pct;
		run_left = 0;
		insert_pct = 50;
		repeat (n_ops) begin
			if (run_left == 0) begin
				case ($urandom_range(2))
					0: insert_pct = 85;
					1: insert_pct = 50;
					default: insert_pct = 15;
				endcase
				run_left = $urandom_range(8, 40);
			end
			op = ($urandom_range(99) < insert_pct) ? MODE_INSERT : MODE_EXTRACT;
			send_op(op, ID_W'($urandom), pick_days());
			run_left--;
		end
	endtask

	task automatic report_field(string field, int want, int got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d actual %0d", $time, field, want, got);
			error_count++;
		end
	endtask

	always @(posedge clk) begin : check_results
		queue_result_t want;
		if (arst_n && done === 1'b1) begin
			if (pending_results.size() == 0) begin
				$display("%0t: result with no transaction pending, expected none actual status %0d",
					$time, status);
				error_count++;
			end else begin
				want = pending_results.pop_front();
				if ($isunknown({status, out_id, out_days, occupancy})) begin
					$display("%0t: unknown result bits, expected %0d/%0d/%0d/%0d actual %b/%b/%b/%b",
						$time, want.status, want.id, want.days, want.occ,
						status, out_id, out_days, occupancy);
					error_count++;
				end else begin
					report_field("status", want.status, status);
					report_field("out_id", want.id, out_id);
					report_field("out_days", want.days, out_days);
					report_field("occupancy", want.occ, occupancy);
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((start && busy === 1'b0) || done === 1'b1)
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_cases();
		test_overflow();
		test_random_mix(170, 25);
		test_random_mix(170, 75);
		test_random_mix(170, 0);
		start <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
